[hdl/eaut_pkg.sv]
package eaut_pkg;

   localparam int unsigned AngleWidth = 16;
   localparam int unsigned RangeWidth = 15;
   localparam int unsigned CountWidth = 8;
   localparam int unsigned TotalWidth = 32;
   localparam int unsigned CsrIndexWidth = 2;

   localparam logic [RangeWidth-1:0] YAW_HALF_RESET   = 15'd1800;
   localparam logic [RangeWidth-1:0] PITCH_HALF_RESET = 15'd9000;
   localparam logic [RangeWidth-1:0] ROLL_HALF_RESET  = 15'd18000;
   localparam logic [CountWidth-1:0] SETTLE_RESET     = 8'd50;
   localparam logic [CountWidth-1:0] COUNT_MAX        = 8'hFF;

   localparam logic signed [AngleWidth-1:0] TURN_MAX = 16'sh7FFF;
   localparam logic signed [AngleWidth-1:0] TURN_MIN = 16'sh8000;

   typedef enum logic [1:0] {
      OP_SAMPLE    = 2'd0,
      OP_RECAL     = 2'd1,
      OP_LINK_LOST = 2'd2,
      OP_LINK_UP   = 2'd3
   } op_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_YAW_HALF   = 2'd0,
      CSR_PITCH_HALF = 2'd1,
      CSR_ROLL_HALF  = 2'd2,
      CSR_SETTLE     = 2'd3
   } csr_index_type;

   typedef struct packed {
      op_type                       operation;
      logic signed [AngleWidth-1:0] yaw_sample;
      logic signed [AngleWidth-1:0] pitch_sample;
      logic signed [AngleWidth-1:0] roll_sample;
   } req_type;

   typedef struct packed {
      logic signed [TotalWidth-1:0] yaw_total;
      logic signed [TotalWidth-1:0] pitch_total;
      logic signed [TotalWidth-1:0] roll_total;
      logic                         calibrated;
      logic                         ready_res;
   } rsp_type;

   typedef struct packed {
      logic apply;
      logic capture;
   } axis_ctl_type;

endpackage

[hdl/euler_angle_unwrap_tracker.sv]
// Multi-turn Euler angle unwrapper.
// Request channel (req_valid, req_stall, req_payload) carries either a raw
// yaw/pitch/roll sample or a control event: recalibrate, link lost, link up.
// Every request yields exactly one response on rsp_valid/rsp_stall/rsp_payload
// with the unwrapped angles relative to the captured offsets and the
// calibrated and ready flags after that request.
// Throughput is one request per cycle while the response is not stalled:
// input register, state update, then totals (one 16x17 multiply and add per
// axis) into the output register.
// csr_write/csr_index/csr_data set the three half ranges and the settle
// count; write them only while no request is in flight.
// Reset clears all angle state, sets the link as lost and loads the default
// half ranges (1800, 9000, 18000) and settle count (50).
// When rsp_stall is high the response holds; the stages behind it fill,
// and req_stall rises once the input register cannot move on.
module euler_angle_unwrap_tracker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  eaut_pkg::req_type                      req_payload,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output eaut_pkg::rsp_type                      rsp_payload,
   input  logic                                   csr_write,
   input  logic [eaut_pkg::CsrIndexWidth-1:0]     csr_index,
   input  logic [eaut_pkg::RangeWidth-1:0]        csr_data
);

   logic [eaut_pkg::RangeWidth-1:0] yaw_half_ff, pitch_half_ff, roll_half_ff;
   logic [eaut_pkg::CountWidth-1:0] settle_ff;

   logic              s1_valid_ff;
   eaut_pkg::req_type s1_req_ff;
   logic              s2_valid_ff;
   logic              rsp_valid_ff;
   eaut_pkg::rsp_type rsp_ff;

   logic rsp_load, s2_free, apply, s1_free;

   logic [eaut_pkg::CountWidth-1:0] count_ff, count_in, count_base;
   logic                            cal_ff, cal_in;
   logic                            lost_ff, lost_in;
   eaut_pkg::axis_ctl_type          axis_ctl;

   logic signed [eaut_pkg::TotalWidth-1:0] yaw_total, pitch_total, roll_total;

   always_ff @(posedge clock) begin
      if (reset) begin
         yaw_half_ff   <= eaut_pkg::YAW_HALF_RESET;
         pitch_half_ff <= eaut_pkg::PITCH_HALF_RESET;
         roll_half_ff  <= eaut_pkg::ROLL_HALF_RESET;
         settle_ff     <= eaut_pkg::SETTLE_RESET;
      end else if (csr_write) begin
         unique case (eaut_pkg::csr_index_type'(csr_index))
            eaut_pkg::CSR_YAW_HALF:   yaw_half_ff   <= csr_data;
            eaut_pkg::CSR_PITCH_HALF: pitch_half_ff <= csr_data;
            eaut_pkg::CSR_ROLL_HALF:  roll_half_ff  <= csr_data;
            eaut_pkg::CSR_SETTLE:     settle_ff     <= csr_data[eaut_pkg::CountWidth-1:0];
            default:                  settle_ff     <= settle_ff;
         endcase
      end
   end

   // stage flow: input register -> state update -> response register
   assign rsp_load  = s2_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign s2_free   = !s2_valid_ff || rsp_load;
   assign apply     = s1_valid_ff && s2_free;
   assign s1_free   = !s1_valid_ff || apply;
   assign req_stall = !s1_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_free) s1_valid_ff <= req_valid;
         if (s2_free) s2_valid_ff <= apply;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_free && req_valid) s1_req_ff <= req_payload;
      if (rsp_load) begin
         rsp_ff.yaw_total   <= yaw_total;
         rsp_ff.pitch_total <= pitch_total;
         rsp_ff.roll_total  <= roll_total;
         rsp_ff.calibrated  <= cal_ff;
         rsp_ff.ready_res   <= cal_ff && !lost_ff;
      end
   end

   always_comb begin
      count_in         = count_ff;
      cal_in           = cal_ff;
      lost_in          = lost_ff;
      count_base       = count_ff;
      axis_ctl.apply   = 1'b0;
      axis_ctl.capture = 1'b0;
      if (apply) begin
         unique case (s1_req_ff.operation)
            eaut_pkg::OP_SAMPLE: begin
               // restart the settle window if the count already exceeds the settle count while uncalibrated
               if (!cal_ff && count_ff > settle_ff) count_base = '0;
               count_in = (count_base != eaut_pkg::COUNT_MAX) ? count_base + 8'd1 : count_base;
               cal_in   = count_in > settle_ff;
               axis_ctl.apply   = 1'b1;
               axis_ctl.capture = !cal_in;
            end
            eaut_pkg::OP_RECAL: begin
               count_in = '0;
               cal_in   = 1'b0;
            end
            eaut_pkg::OP_LINK_LOST: begin
               count_in = '0;
               cal_in   = 1'b0;
               lost_in  = 1'b1;
            end
            eaut_pkg::OP_LINK_UP: begin
               lost_in = 1'b0;
            end
            default: begin
               lost_in = lost_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         cal_ff   <= 1'b0;
         lost_ff  <= 1'b1;
      end else begin
         count_ff <= count_in;
         cal_ff   <= cal_in;
         lost_ff  <= lost_in;
      end
   end

   eaut_axis u_yaw (
      .clock      (clock),
      .reset      (reset),
      .ctl        (axis_ctl),
      .sample     (s1_req_ff.yaw_sample),
      .half_range (yaw_half_ff),
      .total      (yaw_total)
   );

   eaut_axis u_pitch (
      .clock      (clock),
      .reset      (reset),
      .ctl        (axis_ctl),
      .sample     (s1_req_ff.pitch_sample),
      .half_range (pitch_half_ff),
      .total      (pitch_total)
   );

   eaut_axis u_roll (
      .clock      (clock),
      .reset      (reset),
      .ctl        (axis_ctl),
      .sample     (s1_req_ff.roll_sample),
      .half_range (roll_half_ff),
      .total      (roll_total)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_empty_input_takes_request : assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> !req_stall)
      else $error("input register empty but request stalled");

   a_apply_fills_stage2 : assert property (@(posedge clock) disable iff (reset)
      apply |=> s2_valid_ff)
      else $error("applied request lost before response stage");

   a_stage2_holds : assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !rsp_load) |=> s2_valid_ff && !$past(apply))
      else $error("pending state update overwritten");

   a_link_lost_clears : assert property (@(posedge clock) disable iff (reset)
      (apply && s1_req_ff.operation == eaut_pkg::OP_LINK_LOST) |=> (lost_ff && !cal_ff))
      else $error("link loss did not clear calibration");

   a_ready_needs_cal : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.ready_res) |-> rsp_ff.calibrated)
      else $error("ready reported without calibration");

endmodule

[hdl/eaut_axis.sv]
module eaut_axis (
   input  logic                                           clock,
   input  logic                                           reset,
   input  eaut_pkg::axis_ctl_type                         ctl,
   input  logic signed [eaut_pkg::AngleWidth-1:0]         sample,
   input  logic        [eaut_pkg::RangeWidth-1:0]         half_range,
   output logic signed [eaut_pkg::TotalWidth-1:0]         total
);

   logic signed [eaut_pkg::AngleWidth-1:0] cur_ff, cur_in;
   logic signed [eaut_pkg::AngleWidth-1:0] off_ff, off_in;
   logic signed [eaut_pkg::AngleWidth-1:0] turns_ff, turns_in;

   logic signed [eaut_pkg::AngleWidth:0]   diff;
   logic signed [eaut_pkg::AngleWidth:0]   limit;
   logic                                   wrap_up;
   logic                                   wrap_down;
   logic signed [eaut_pkg::AngleWidth:0]   span;
   logic signed [eaut_pkg::TotalWidth-1:0] product;
   logic signed [eaut_pkg::AngleWidth:0]   rel;

   always_comb begin
      diff      = {sample[eaut_pkg::AngleWidth-1], sample} - {cur_ff[eaut_pkg::AngleWidth-1], cur_ff};
      limit     = {2'b00, half_range};
      wrap_up   = diff < -limit;
      wrap_down = diff > limit;
      cur_in    = cur_ff;
      off_in    = off_ff;
      turns_in  = turns_ff;
      if (ctl.apply) begin
         cur_in = sample;
         if (ctl.capture) begin
            off_in   = sample;
            turns_in = '0;
         end else if (wrap_up) begin
            if (turns_ff != eaut_pkg::TURN_MAX) turns_in = turns_ff + 16'sd1;
         end else if (wrap_down) begin
            if (turns_ff != eaut_pkg::TURN_MIN) turns_in = turns_ff - 16'sd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff   <= '0;
         off_ff   <= '0;
         turns_ff <= '0;
      end else begin
         cur_ff   <= cur_in;
         off_ff   <= off_in;
         turns_ff <= turns_in;
      end
   end

   // total = turns * full turn + (current - offset)
   always_comb begin
      span    = {1'b0, half_range, 1'b0};
      product = (eaut_pkg::TotalWidth)'(turns_ff) * (eaut_pkg::TotalWidth)'(span);
      rel     = {cur_ff[eaut_pkg::AngleWidth-1], cur_ff} - {off_ff[eaut_pkg::AngleWidth-1], off_ff};
      total   = product
              + {{(eaut_pkg::TotalWidth-eaut_pkg::AngleWidth-1){rel[eaut_pkg::AngleWidth]}}, rel};
   end

endmodule

[sim/euler_angle_unwrap_tracker_test.sv]
module euler_angle_unwrap_tracker_test;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   eaut_pkg::req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   eaut_pkg::rsp_type rsp_payload;
   logic csr_write = 1'b0;
   logic [eaut_pkg::CsrIndexWidth-1:0] csr_index = '0;
   logic [eaut_pkg::RangeWidth-1:0] csr_data = '0;

   euler_angle_unwrap_tracker dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // tracker state and settings as the block should hold them
   logic [eaut_pkg::RangeWidth-1:0] half_range [3];
   logic [eaut_pkg::CountWidth-1:0] settle_count;
   int angle_now [3];
   int angle_zero [3];
   int turns [3];
   int unsigned samples_taken;
   bit calibrated_now;
   bit link_lost;

   eaut_pkg::rsp_type awaited_totals [$];
   eaut_pkg::rsp_type want_rsp;

   int unsigned error_count = 0;
   int unsigned requests_sent = 0;
   int unsigned responses_checked = 0;
   int unsigned settings_written = 0;
   int unsigned burst_left = 0;
   bit sender_gaps = 1'b1;
   int unsigned stall_age = 0;
   int unsigned stall_mode = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("euler_angle_unwrap_tracker_test: done, errors");
      $finish;
   end

   function automatic eaut_pkg::rsp_type unwrap_request(input eaut_pkg::req_type item);
      eaut_pkg::rsp_type result;
      int s [3];
      int d;
      int lim;
      int k;
      longint sum [3];
      s[0] = $signed(item.yaw_sample);
      s[1] = $signed(item.pitch_sample);
      s[2] = $signed(item.roll_sample);
      case (item.operation)
         eaut_pkg::OP_SAMPLE: begin
            if (!calibrated_now && samples_taken > settle_count) samples_taken = 0;
            if (samples_taken < eaut_pkg::COUNT_MAX) samples_taken++;
            calibrated_now = samples_taken > settle_count;
            for (k = 0; k < 3; k++) begin
               if (!calibrated_now) begin
                  angle_now[k] = s[k];
                  angle_zero[k] = s[k];
                  turns[k] = 0;
               end else begin
                  d = s[k] - angle_now[k];
                  lim = int'(half_range[k]);
                  if (d < -lim) begin
                     if (turns[k] < int'(eaut_pkg::TURN_MAX)) turns[k]++;
                  end else if (d > lim) begin
                     if (turns[k] > int'(eaut_pkg::TURN_MIN)) turns[k]--;
                  end
                  angle_now[k] = s[k];
               end
            end
         end
         eaut_pkg::OP_RECAL: begin
            samples_taken = 0;
            calibrated_now = 1'b0;
         end
         eaut_pkg::OP_LINK_LOST: begin
            samples_taken = 0;
            calibrated_now = 1'b0;
            link_lost = 1'b1;
         end
         default: link_lost = 1'b0;
      endcase
      for (k = 0; k < 3; k++)
         sum[k] = longint'(turns[k]) * 2 * longint'(half_range[k])
                + longint'(angle_now[k]) - longint'(angle_zero[k]);
      result.yaw_total = sum[0][31:0];
      result.pitch_total = sum[1][31:0];
      result.roll_total = sum[2][31:0];
      result.calibrated = calibrated_now;
      result.ready_res = calibrated_now && !link_lost;
      return result;
   endfunction

   // next sample for one axis: mostly steps around the wrap threshold
   function automatic int next_sample(input int axis);
      int lim;
      int v;
      lim = int'(half_range[axis]);
      case ($urandom_range(0, 9))
         0, 1, 2, 3: v = angle_now[axis] + int'($urandom_range(0, 2 * lim)) - lim;
         4: v = angle_now[axis] + lim;
         5: v = angle_now[axis] - lim;
         6: v = angle_now[axis] + lim + 1;
         7: v = angle_now[axis] - lim - 1;
         8: v = int'($urandom_range(0, 65535)) - 32768;
         default: v = $urandom_range(0, 1) ? 32767 : -32768;
      endcase
      if (v > 32767 || v < -32768) v = int'($urandom_range(0, 65535)) - 32768;
      return v;
   endfunction

   function automatic int unsigned pick_half_range(input int unsigned fallback);
      case ($urandom_range(0, 5))
         0: return 1;
         1: return 32767;
         2: return $urandom_range(1, 64);
         3: return $urandom_range(1, 32767);
         4: return fallback;
         default: return $urandom_range(100, 4000);
      endcase
   endfunction

   task automatic pace_sender();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(1, 24);
         if (sender_gaps) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   endtask

   task automatic send_request(input eaut_pkg::op_type op, input int yaw, input int pitch,
                               input int roll);
      eaut_pkg::req_type item;
      item.operation = op;
      item.yaw_sample = yaw[eaut_pkg::AngleWidth-1:0];
      item.pitch_sample = pitch[eaut_pkg::AngleWidth-1:0];
      item.roll_sample = roll[eaut_pkg::AngleWidth-1:0];
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      awaited_totals.push_back(unwrap_request(item));
      requests_sent++;
      pace_sender();
   endtask

   task automatic send_event(input eaut_pkg::op_type op);
      send_request(op, $urandom, $urandom, $urandom);
   endtask

   // hold the sender until every awaited response is in, then let the pipe settle
   task automatic drain_responses();
      int n;
      req_valid <= 1'b0;
      for (n = 0; n < 5000 && awaited_totals.size() != 0; n++) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input eaut_pkg::csr_index_type which,
                                 input int unsigned value);
      csr_write <= 1'b1;
      csr_index <= which;
      csr_data <= value[eaut_pkg::RangeWidth-1:0];
      @(posedge clock);
   endtask

   task automatic write_settings(input int unsigned yaw_half, input int unsigned pitch_half,
                                 input int unsigned roll_half, input int unsigned settle);
      write_register(eaut_pkg::CSR_YAW_HALF, yaw_half);
      write_register(eaut_pkg::CSR_PITCH_HALF, pitch_half);
      write_register(eaut_pkg::CSR_ROLL_HALF, roll_half);
      write_register(eaut_pkg::CSR_SETTLE, settle);
      csr_write <= 1'b0;
      half_range[0] = yaw_half[eaut_pkg::RangeWidth-1:0];
      half_range[1] = pitch_half[eaut_pkg::RangeWidth-1:0];
      half_range[2] = roll_half[eaut_pkg::RangeWidth-1:0];
      settle_count = settle[eaut_pkg::CountWidth-1:0];
      settings_written++;
   endtask

   task automatic compare_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         if (error_count < 40)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field,
                     $signed(want), $signed(got));
         error_count++;
      end
   endtask

   // response side: check each accepted response, stall on a shifting pattern
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_totals.size() == 0) begin
            if (error_count < 40)
               $display("%0t: response with none awaited, expected nothing, got %p",
                        $time, rsp_payload);
            error_count++;
         end else begin
            want_rsp = awaited_totals.pop_front();
            compare_field("yaw_total", want_rsp.yaw_total, rsp_payload.yaw_total);
            compare_field("pitch_total", want_rsp.pitch_total, rsp_payload.pitch_total);
            compare_field("roll_total", want_rsp.roll_total, rsp_payload.roll_total);
            compare_field("calibrated", want_rsp.calibrated, rsp_payload.calibrated);
            compare_field("ready_res", want_rsp.ready_res, rsp_payload.ready_res);
            responses_checked++;
         end
      end
      stall_age++;
      if (stall_age >= 150) begin
         stall_age = 0;
         stall_mode = $urandom_range(0, 3);
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= (stall_age % 4 != 0);
      endcase
   end

   task automatic test_defaults();
      send_event(eaut_pkg::OP_LINK_UP);
      send_request(eaut_pkg::OP_SAMPLE, 32767, -32768, 32767);
   endtask

   // settle of zero: the next sample tracks straight away against the old angles
   task automatic test_settle_zero();
      drain_responses();
      write_settings(1, 32767, 1800, 0);
      send_request(eaut_pkg::OP_SAMPLE, -32768, 32767, 0);
      send_request(eaut_pkg::OP_SAMPLE, -32767, 0, 1801);
      send_request(eaut_pkg::OP_SAMPLE, -32765, -32768, 1);
   endtask

   task automatic test_control_events();
      send_event(eaut_pkg::OP_RECAL);
      send_request(eaut_pkg::OP_SAMPLE, -1, 1, 0);
      send_event(eaut_pkg::OP_LINK_LOST);
      send_request(eaut_pkg::OP_SAMPLE, 0, 0, -1);
      send_event(eaut_pkg::OP_LINK_UP);
   endtask

   // lowering the settle count mid-capture restarts the count
   task automatic test_settle_restart();
      drain_responses();
      write_settings(eaut_pkg::YAW_HALF_RESET, eaut_pkg::PITCH_HALF_RESET,
                     eaut_pkg::ROLL_HALF_RESET, 3);
      send_event(eaut_pkg::OP_RECAL);
      send_request(eaut_pkg::OP_SAMPLE, 100, -200, 300);
      send_request(eaut_pkg::OP_SAMPLE, 110, -210, 310);
      drain_responses();
      write_settings(eaut_pkg::YAW_HALF_RESET, eaut_pkg::PITCH_HALF_RESET,
                     eaut_pkg::ROLL_HALF_RESET, 1);
      send_request(eaut_pkg::OP_SAMPLE, 120, -220, 320);
      send_request(eaut_pkg::OP_SAMPLE, 2000, -9500, 18400);
   endtask

   // yaw walks down and pitch walks up in wrapping steps, many turns each way
   task automatic test_turn_walk();
      int lap;
      int n;
      drain_responses();
      write_settings(1, 1, 1, 1);
      sender_gaps = 1'b0;
      send_event(eaut_pkg::OP_RECAL);
      send_request(eaut_pkg::OP_SAMPLE, 32767, -32768, 0);
      for (lap = 0; lap < 2; lap++) begin
         send_request(eaut_pkg::OP_SAMPLE, 32767, -32768, 0);
         for (n = 1; n <= 120; n++)
            send_request(eaut_pkg::OP_SAMPLE, 32767 - 2 * n, -32768 + 2 * n, 0);
      end
      sender_gaps = 1'b1;
   endtask

   task automatic test_wide_totals();
      drain_responses();
      write_settings(32767, 32767, 32767, 0);
      send_request(eaut_pkg::OP_SAMPLE, -32767, 32766, 0);
      send_request(eaut_pkg::OP_SAMPLE, 32767, -32768, 0);
   endtask

   task automatic test_random_tracking();
      int unsigned sent_here;
      int unsigned phase_len;
      int unsigned settle;
      int unsigned event_pct;
      int unsigned pick;
      bit deep_done;
      int n;
      sent_here = 0;
      deep_done = 1'b0;
      while (sent_here < 1450) begin
         drain_responses();
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: settle = $urandom_range(0, 4);
            5: settle = 0;
            6: settle = eaut_pkg::SETTLE_RESET;
            7: settle = $urandom_range(5, 20);
            8: settle = deep_done ? 1 : 254;
            default: settle = 1;
         endcase
         if (settle == 254) deep_done = 1'b1;
         write_settings(pick_half_range(eaut_pkg::YAW_HALF_RESET),
                        pick_half_range(eaut_pkg::PITCH_HALF_RESET),
                        pick_half_range(eaut_pkg::ROLL_HALF_RESET), settle);
         phase_len = (settle > 20) ? 320 : $urandom_range(60, 200);
         event_pct = (settle > 200) ? 0 : (settle > 20) ? 1 : 12;
         sender_gaps = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 1)) send_event(eaut_pkg::OP_LINK_UP);
         for (n = 0; n < phase_len; n++) begin
            pick = $urandom_range(0, 99);
            if (pick >= event_pct)
               send_request(eaut_pkg::OP_SAMPLE, next_sample(0), next_sample(1),
                            next_sample(2));
            else if (pick % 3 == 0)
               send_event(eaut_pkg::OP_RECAL);
            else if (pick % 3 == 1)
               send_event(eaut_pkg::OP_LINK_LOST);
            else
               send_event(eaut_pkg::OP_LINK_UP);
         end
         sent_here += phase_len;
      end
   endtask

   initial begin
      half_range[0] = eaut_pkg::YAW_HALF_RESET;
      half_range[1] = eaut_pkg::PITCH_HALF_RESET;
      half_range[2] = eaut_pkg::ROLL_HALF_RESET;
      settle_count = eaut_pkg::SETTLE_RESET;
      for (int k = 0; k < 3; k++) begin
         angle_now[k] = 0;
         angle_zero[k] = 0;
         turns[k] = 0;
      end
      samples_taken = 0;
      calibrated_now = 1'b0;
      link_lost = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_defaults();
      test_settle_zero();
      test_control_events();
      test_settle_restart();
      test_turn_walk();
      test_wide_totals();
      test_random_tracking();

      drain_responses();
      repeat (8) @(posedge clock);
      if (awaited_totals.size() != 0) begin
         $display("%0t: responses missing, expected %0d more, got none", $time,
                  awaited_totals.size());
         error_count++;
      end
      $display("covered %0d requests, %0d responses checked, %0d register settings,",
               requests_sent, responses_checked, settings_written);
      $display("all request kinds, wrap thresholds at both ends, long turn walks both ways");
      if (error_count == 0)
         $display("euler_angle_unwrap_tracker_test: done, clean");
      else
         $display("euler_angle_unwrap_tracker_test: done, errors");
      $finish;
   end

endmodule
